// ===== sv/fsmt_pkg.sv =====
// fsmt_pkg: shared types, codes and reset contents for the programmable FSM table.
// Used by fsmt_table, fsmt_ctrl and programmable_fsm_table. No dependencies.
`timescale 1ns / 1ps

package fsmt_pkg;

	localparam int NUM_STATES = 8;
	localparam int STATE_W    = 3;
	localparam logic [STATE_W-1:0] LAST_IDX = STATE_W'(NUM_STATES - 1);

	localparam logic [1:0] OP_STEP   = 2'd0;
	localparam logic [1:0] OP_CHANGE = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;
	localparam logic [1:0] OP_CHECK  = 2'd3;

	localparam logic [1:0] KIND_STEP  = 2'd0;
	localparam logic [1:0] KIND_ROW   = 2'd1;
	localparam logic [1:0] KIND_UNREACH = 2'd2;

	typedef logic [STATE_W-1:0] state_t;

	typedef struct packed {
		state_t one;
		state_t zero;
	} row_t;

	typedef struct packed {
		logic   en;
		state_t addr;
		row_t   data;
	} tbl_wr_t;

	function automatic row_t reset_row(input state_t s);
		row_t r;
		case (s)
			3'd0:    r = '{one: 3'd4, zero: 3'd7};
			3'd1:    r = '{one: 3'd3, zero: 3'd5};
			3'd2:    r = '{one: 3'd0, zero: 3'd6};
			3'd3:    r = '{one: 3'd1, zero: 3'd4};
			3'd4:    r = '{one: 3'd5, zero: 3'd7};
			3'd5:    r = '{one: 3'd5, zero: 3'd2};
			3'd6:    r = '{one: 3'd0, zero: 3'd1};
			3'd7:    r = '{one: 3'd6, zero: 3'd3};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/programmable_fsm_table.sv =====
// Programmable FSM table: step, change edge, dump table, unreachable check.
// Step: the result is registered in S_STEP once the output slot is free; dump rows
// follow one per cycle while out_stall is low; check scans all 8 rows, then reports.
// A new command is taken only back in idle (in_stall), as all use the single read port.
// Reset: arst_n async active low loads the initial table and current state B.
// Depends on fsmt_pkg, fsmt_table, fsmt_ctrl.
`timescale 1ns / 1ps

module programmable_fsm_table (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic       edge_bit,
	input  logic [2:0] target_state,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] report_kind,
	output logic [2:0] state_index,
	output logic [2:0] next_on_zero,
	output logic [2:0] next_on_one,
	output logic       unreachable_found,
	output logic       last
);

	fsmt_pkg::tbl_wr_t wr;
	fsmt_pkg::state_t  rd_addr;
	fsmt_pkg::row_t    rd_data;

	fsmt_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fsmt_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.edge_bit          (edge_bit),
		.target_state      (target_state),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.report_kind       (report_kind),
		.state_index       (state_index),
		.next_on_zero      (next_on_zero),
		.next_on_one       (next_on_one),
		.unreachable_found (unreachable_found),
		.last              (last),
		.wr                (wr),
		.rd_addr           (rd_addr),
		.rd_data           (rd_data)
	);

endmodule

// ===== sv/fsmt_table.sv =====
// fsmt_table: transition table registers, one write port and one read port.
// Depends on fsmt_pkg.
`timescale 1ns / 1ps

module fsmt_table (
	input  logic              clk,
	input  logic              arst_n,
	input  fsmt_pkg::tbl_wr_t wr,
	input  fsmt_pkg::state_t  rd_addr,
	output fsmt_pkg::row_t    rd_data
);

	fsmt_pkg::row_t rows_q [fsmt_pkg::NUM_STATES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fsmt_pkg::NUM_STATES; i++) begin
				rows_q[i] <= fsmt_pkg::reset_row(fsmt_pkg::STATE_W'(i));
			end
		end else if (wr.en) begin
			rows_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = rows_q[rd_addr];

endmodule

// ===== sv/fsmt_ctrl.sv =====
// fsmt_ctrl: sequencer that walks the table read port, tracks the current state
// and drives the registered result channel. Depends on fsmt_pkg.
`timescale 1ns / 1ps

module fsmt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic              edge_bit,
	input  fsmt_pkg::state_t  target_state,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        report_kind,
	output fsmt_pkg::state_t  state_index,
	output fsmt_pkg::state_t  next_on_zero,
	output fsmt_pkg::state_t  next_on_one,
	output logic              unreachable_found,
	output logic              last,
	output fsmt_pkg::tbl_wr_t wr,
	output fsmt_pkg::state_t  rd_addr,
	input  fsmt_pkg::row_t    rd_data
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_STEP   = 3'd1;
	localparam logic [2:0] S_CHANGE = 3'd2;
	localparam logic [2:0] S_DUMP   = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_REPORT = 3'd5;

	logic [2:0]                          state_q;
	logic                                edge_q;
	fsmt_pkg::state_t                    tgt_q;
	fsmt_pkg::state_t                    cur_q;
	fsmt_pkg::state_t                    idx_q;
	logic [fsmt_pkg::NUM_STATES-1:0]     entered_q;
	logic                                out_valid_q;
	logic [1:0]                          kind_q;
	fsmt_pkg::state_t                    sidx_q;
	fsmt_pkg::state_t                    n0_q;
	fsmt_pkg::state_t                    n1_q;
	logic                                found_q;
	logic                                last_q;

	logic                                slot_free;
	logic                                load;
	logic [1:0]                          kind_d;
	fsmt_pkg::state_t                    sidx_d;
	fsmt_pkg::state_t                    n0_d;
	fsmt_pkg::state_t                    n1_d;
	logic                                found_d;
	logic                                last_d;
	fsmt_pkg::state_t                    step_dst;
	fsmt_pkg::state_t                    free_idx;
	logic                                free_any;
	logic [fsmt_pkg::NUM_STATES-1:0]     hit;

	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign rd_addr   = (state_q == S_DUMP || state_q == S_SCAN) ? idx_q : cur_q;
	assign step_dst  = edge_q ? rd_data.one : rd_data.zero;

	always_comb begin
		hit = '0;
		hit[rd_data.zero] = 1'b1;
		hit[rd_data.one]  = 1'b1;
	end

	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = fsmt_pkg::NUM_STATES - 1; i >= 0; i--) begin
			if (!entered_q[i]) begin
				free_idx = fsmt_pkg::STATE_W'(i);
				free_any = 1'b1;
			end
		end
	end

	always_comb begin
		wr.en   = (state_q == S_CHANGE);
		wr.addr = cur_q;
		wr.data = rd_data;
		if (edge_q) begin
			wr.data.one = tgt_q;
		end else begin
			wr.data.zero = tgt_q;
		end
	end

	always_comb begin
		load    = 1'b0;
		kind_d  = fsmt_pkg::KIND_STEP;
		sidx_d  = '0;
		n0_d    = '0;
		n1_d    = '0;
		found_d = 1'b0;
		last_d  = 1'b1;
		case (state_q)
			S_STEP: begin
				load   = slot_free;
				sidx_d = step_dst;
			end
			S_DUMP: begin
				load   = slot_free;
				kind_d = fsmt_pkg::KIND_ROW;
				sidx_d = idx_q;
				n0_d   = rd_data.zero;
				n1_d   = rd_data.one;
				last_d = (idx_q == fsmt_pkg::LAST_IDX);
			end
			S_REPORT: begin
				load    = slot_free;
				kind_d  = fsmt_pkg::KIND_UNREACH;
				sidx_d  = free_idx;
				found_d = free_any;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= fsmt_pkg::STATE_W'(1);
			idx_q       <= '0;
			entered_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q     <= '0;
						entered_q <= '0;
						case (operation)
							fsmt_pkg::OP_STEP:   state_q <= S_STEP;
							fsmt_pkg::OP_CHANGE: state_q <= S_CHANGE;
							fsmt_pkg::OP_DUMP:   state_q <= S_DUMP;
							default:             state_q <= S_SCAN;
						endcase
					end
				end
				S_STEP: begin
					if (slot_free) begin
						cur_q   <= step_dst;
						state_q <= S_IDLE;
					end
				end
				S_CHANGE: begin
					cur_q   <= tgt_q;
					state_q <= S_IDLE;
				end
				S_DUMP: begin
					if (slot_free) begin
						idx_q <= idx_q + fsmt_pkg::STATE_W'(1);
						if (idx_q == fsmt_pkg::LAST_IDX) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SCAN: begin
					entered_q <= entered_q | hit;
					idx_q     <= idx_q + fsmt_pkg::STATE_W'(1);
					if (idx_q == fsmt_pkg::LAST_IDX) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			edge_q <= edge_bit;
			tgt_q  <= target_state;
		end
		if (load) begin
			kind_q  <= kind_d;
			sidx_q  <= sidx_d;
			n0_q    <= n0_d;
			n1_q    <= n1_d;
			found_q <= found_d;
			last_q  <= last_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign report_kind       = kind_q;
	assign state_index       = sidx_q;
	assign next_on_zero      = n0_q;
	assign next_on_one       = n1_q;
	assign unreachable_found = found_q;
	assign last              = last_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for programmable_fsm_table: directed and random step, change,
// dump and check transactions against an in-bench model of the table. Depends on fsmt_pkg.
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 30;

	localparam fsmt_pkg::row_t RESET_ROWS [fsmt_pkg::NUM_STATES] = '{
		6'o47, 6'o35, 6'o06, 6'o14, 6'o57, 6'o52, 6'o01, 6'o63
	};

	typedef struct {
		logic [1:0]       kind;
		fsmt_pkg::state_t idx;
		fsmt_pkg::state_t n0;
		fsmt_pkg::state_t n1;
		logic             found;
		logic             last;
	} report_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] operation = fsmt_pkg::OP_STEP;
	logic       edge_bit = 1'b0;
	logic [2:0] target_state = 3'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] report_kind;
	logic [2:0] state_index;
	logic [2:0] next_on_zero;
	logic [2:0] next_on_one;
	logic       unreachable_found;
	logic       last;

	fsmt_pkg::row_t   fsm_rows [fsmt_pkg::NUM_STATES];
	fsmt_pkg::state_t cur_state;
	report_t pending_reports [$];
	int      errors = 0;
	int      burst_left = 0;
	bit      gaps_on = 1'b0;
	int      stall_level = 0;
	int      stall_run = 0;

	programmable_fsm_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.edge_bit(edge_bit),
		.target_state(target_state),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.report_kind(report_kind),
		.state_index(state_index),
		.next_on_zero(next_on_zero),
		.next_on_one(next_on_one),
		.unreachable_found(unreachable_found),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic push_report(input logic [1:0] kind, input fsmt_pkg::state_t idx,
			input fsmt_pkg::state_t n0, input fsmt_pkg::state_t n1, input logic found,
			input logic lst);
		report_t r;
		r.kind  = kind;
		r.idx   = idx;
		r.n0    = n0;
		r.n1    = n1;
		r.found = found;
		r.last  = lst;
		pending_reports.push_back(r);
	endtask

	task automatic predict_reports(input logic [1:0] op, input logic b,
			input fsmt_pkg::state_t tgt);
		logic [fsmt_pkg::NUM_STATES-1:0] entered;
		int hole;
		entered = '0;
		hole = -1;
		case (op)
			fsmt_pkg::OP_STEP: begin
				cur_state = b ? fsm_rows[cur_state].one : fsm_rows[cur_state].zero;
				push_report(fsmt_pkg::KIND_STEP, cur_state, '0, '0, 1'b0, 1'b1);
			end
			fsmt_pkg::OP_CHANGE: begin
				if (b)
					fsm_rows[cur_state].one = tgt;
				else
					fsm_rows[cur_state].zero = tgt;
				cur_state = tgt;
			end
			fsmt_pkg::OP_DUMP: begin
				for (int i = 0; i < fsmt_pkg::NUM_STATES; i++)
					push_report(fsmt_pkg::KIND_ROW, fsmt_pkg::state_t'(i), fsm_rows[i].zero,
						fsm_rows[i].one, 1'b0, i == fsmt_pkg::NUM_STATES - 1);
			end
			default: begin
				for (int i = 0; i < fsmt_pkg::NUM_STATES; i++) begin
					entered[fsm_rows[i].zero] = 1'b1;
					entered[fsm_rows[i].one]  = 1'b1;
				end
				for (int i = fsmt_pkg::NUM_STATES - 1; i >= 0; i--)
					if (!entered[i])
						hole = i;
				if (hole >= 0)
					push_report(fsmt_pkg::KIND_UNREACH, fsmt_pkg::state_t'(hole), '0, '0,
						1'b1, 1'b1);
				else
					push_report(fsmt_pkg::KIND_UNREACH, '0, '0, '0, 1'b0, 1'b1);
			end
		endcase
	endtask

	task automatic send_item(input logic [1:0] op, input logic b, input fsmt_pkg::state_t tgt);
		operation    <= op;
		edge_bit     <= b;
		target_state <= tgt;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_reports(op, b, tgt);
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				burst_left = $urandom_range(1, 10);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_random(input int count, input bit sparse);
		int r;
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (sparse)
				op = (r < 70) ? fsmt_pkg::OP_CHANGE : (r < 85) ? fsmt_pkg::OP_CHECK :
					(r < 93) ? fsmt_pkg::OP_STEP : fsmt_pkg::OP_DUMP;
			else
				op = (r < 45) ? fsmt_pkg::OP_STEP : (r < 75) ? fsmt_pkg::OP_CHANGE :
					(r < 85) ? fsmt_pkg::OP_DUMP : fsmt_pkg::OP_CHECK;
			send_item(op, 1'($urandom_range(0, 1)),
				sparse ? fsmt_pkg::state_t'($urandom_range(0, 2)) :
					fsmt_pkg::state_t'($urandom_range(0, 7)));
		end
	endtask

	task automatic test_reset_contents;
		send_item(fsmt_pkg::OP_DUMP, 1'b0, 3'd0);
		send_item(fsmt_pkg::OP_CHECK, 1'b1, 3'd7);
	endtask

	task automatic test_step_and_change;
		send_item(fsmt_pkg::OP_STEP, 1'b0, 3'd7);
		send_item(fsmt_pkg::OP_STEP, 1'b1, 3'd0);
		send_item(fsmt_pkg::OP_CHANGE, 1'b0, 3'd0);
		send_item(fsmt_pkg::OP_CHANGE, 1'b1, 3'd7);
		send_item(fsmt_pkg::OP_STEP, 1'b1, 3'd5);
		send_item(fsmt_pkg::OP_STEP, 1'b0, 3'd2);
		send_item(fsmt_pkg::OP_CHANGE, 1'b1, 3'd7);
		send_item(fsmt_pkg::OP_CHANGE, 1'b0, 3'd7);
		send_item(fsmt_pkg::OP_DUMP, 1'b1, 3'd3);
		send_item(fsmt_pkg::OP_CHECK, 1'b0, 3'd0);
		send_item(fsmt_pkg::OP_STEP, 1'b0, 3'd0);
		send_item(fsmt_pkg::OP_STEP, 1'b1, 3'd0);
	endtask

	task automatic test_random_no_idle;
		gaps_on = 1'b0;
		stall_level = 0;
		send_random(80, 1'b0);
	endtask

	task automatic test_random_bursty;
		gaps_on = 1'b1;
		stall_level = 3;
		send_random(110, 1'b0);
	endtask

	task automatic test_sparse_targets;
		gaps_on = 1'b1;
		stall_level = 2;
		send_random(60, 1'b1);
	endtask

	task automatic test_heavy_backpressure;
		gaps_on = 1'b1;
		stall_level = 7;
		send_random(80, 1'b0);
	endtask

	always @(posedge clk) begin
		if (stall_level == 0) begin
			out_stall <= 1'b0;
		end else if (stall_run != 0) begin
			stall_run <= stall_run - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) < stall_level) begin
			stall_run <= $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		report_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none actual kind %0d idx %0d",
					$time, report_kind, state_index);
			end else begin
				r = pending_reports.pop_front();
				check_field("report_kind", int'(r.kind), int'(report_kind));
				check_field("state_index", int'(r.idx), int'(state_index));
				check_field("next_on_zero", int'(r.n0), int'(next_on_zero));
				check_field("next_on_one", int'(r.n1), int'(next_on_one));
				check_field("unreachable_found", int'(r.found), int'(unreachable_found));
				check_field("last", int'(r.last), int'(last));
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		for (int i = 0; i < fsmt_pkg::NUM_STATES; i++)
			fsm_rows[i] = RESET_ROWS[i];
		cur_state = 3'd1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_contents();
		test_step_and_change();
		test_random_no_idle();
		test_random_bursty();
		test_sparse_targets();
		test_heavy_backpressure();

		if (in_valid)
			in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
